@@ rtl/core/multilane_fir_filter_unit_macros.svh @@
// ----------------------------------------------------------------------------
// multilane_fir_filter_unit_macros
// Assertion helpers used by the filter RTL.
// ----------------------------------------------------------------------------
`ifndef MULTILANE_FIR_FILTER_UNIT_MACROS_SVH
`define MULTILANE_FIR_FILTER_UNIT_MACROS_SVH

// same-cycle implication
`define MFIR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MFIR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/mfir_pkg.sv @@
// ----------------------------------------------------------------------------
// mfir_pkg
// Types and constants of the multilane FIR filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mfir_pkg;

   localparam int DATA_W      = 16;
   localparam int LANE_W      = 2;
   localparam int IDX_W       = 6;
   localparam int TAP_REG_W   = 7;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 7;
   localparam int REQ_USER_W  = 1;
   localparam int REQ_DATA_W  = 56;
   localparam int RSP_DATA_W  = 40;

   // request tdata layout
   localparam int REQ_LANE_LO = 0;
   localparam int REQ_RE_LO   = 2;
   localparam int REQ_IM_LO   = 18;
   localparam int REQ_IDX_LO  = 34;
   localparam int REQ_COEF_LO = 40;

   // response tdata layout
   localparam int RSP_LANE_LO = 0;
   localparam int RSP_RE_LO   = 2;
   localparam int RSP_IM_LO   = 18;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_COEF   = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_TAP_COUNT    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_COMPLEX_MODE = 1'b1;

   typedef logic signed [DATA_W-1:0] sample_type;

   typedef struct packed {
      logic clear;
      logic feed;
   } mac_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/core/mfir_mac.sv @@
// ----------------------------------------------------------------------------
// mfir_mac
// Shared complex-by-real multiply-accumulate unit with Q1.15 round and
// saturate on the accumulated sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfir_mac #(
   parameter int ACC_W = 38
) (
   input  wire                     clock,
   input  wire                     reset,
   input  mfir_pkg::mac_ctrl_type  ctrl,
   input  mfir_pkg::sample_type    op_re,
   input  mfir_pkg::sample_type    op_im,
   input  mfir_pkg::sample_type    op_coef,
   output mfir_pkg::sample_type    res_re,
   output mfir_pkg::sample_type    res_im
);
   import mfir_pkg::*;

   logic signed [2*DATA_W-1:0] prod_re_ff, prod_im_ff;
   logic                       prod_vld_ff;
   logic signed [ACC_W-1:0]    acc_re_ff, acc_im_ff;

   function automatic logic [DATA_W-1:0] rnd_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W:0]  sum;
      logic signed [ACC_W:0]  q;
      logic [ACC_W-DATA_W+1:0] hi;
      logic                    fits;
      sum  = (ACC_W+1)'(acc) + (ACC_W+1)'(16384);
      q    = sum >>> (DATA_W-1);
      hi   = q[ACC_W:DATA_W-1];
      fits = (&hi) || !(|hi);
      if (fits) begin
         return q[DATA_W-1:0];
      end else if (q[ACC_W]) begin
         return {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         return {1'b0, {(DATA_W-1){1'b1}}};
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctrl.feed;
      end
      prod_re_ff <= op_re * op_coef;
      prod_im_ff <= op_im * op_coef;
      if (ctrl.clear) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_re_ff <= acc_re_ff + ACC_W'(prod_re_ff);
         acc_im_ff <= acc_im_ff + ACC_W'(prod_im_ff);
      end
   end

   assign res_re = rnd_sat(acc_re_ff);
   assign res_im = rnd_sat(acc_im_ff);

endmodule

`default_nettype wire

@@ rtl/core/multilane_fir_filter_unit.sv @@
// ----------------------------------------------------------------------------
// multilane_fir_filter_unit
// Direct-form FIR filter over several lanes, one shared MAC walking the taps.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | contents
//  req_    | in  | req_tvalid/req_tready  | sample for a lane or coefficient write
//  rsp_    | out | rsp_tvalid/rsp_tready  | filtered sample of a lane
//  csr_    | in  | csr_we                 | tap_count, complex_mode
//
//  A sample item passes accept, tap 0, taps-1 further taps and the MAC
//  drain; the MAC unit takes one tap per cycle.
//  A coefficient write is taken in S_IDLE and gives no item on rsp_.
//  After reset a clearing pass zeroes history, pointers and coefficients
//  while req_tready stays low.
//  A result waits in the output register; a stalled rsp_ only blocks the
//  next item at its last cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "multilane_fir_filter_unit_macros.svh"

module multilane_fir_filter_unit #(
   parameter int MAX_TAPS = 64,
   parameter int LANES    = 4
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   // lane[1:0], sample_re[17:2], sample_im[33:18], coef_index[39:34], coef_value[55:40]
   input  wire  [mfir_pkg::REQ_DATA_W-1:0]       req_tdata,
   // kind[0]
   input  wire  [mfir_pkg::REQ_USER_W-1:0]       req_tuser,
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   // out_lane[1:0], out_re[17:2], out_im[33:18], zero[39:34]
   output logic [mfir_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  wire                                   csr_we,
   input  wire  [mfir_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [mfir_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import mfir_pkg::*;

   localparam int HIST_LEN  = MAX_TAPS - 1;
   localparam int SW        = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
   localparam int LW        = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int DAW       = LW + SW;
   localparam int DLY_DEPTH = LANES * (2 ** SW);
   localparam int CAW       = $clog2(MAX_TAPS);
   localparam int TW        = $clog2(MAX_TAPS + 1);
   localparam int CMPW      = (TW > TAP_REG_W) ? TW : TAP_REG_W;
   localparam int CLR_LEN   = (DLY_DEPTH > MAX_TAPS) ? DLY_DEPTH : MAX_TAPS;
   localparam int CW        = (CLR_LEN > 1) ? $clog2(CLR_LEN) : 1;
   localparam int ACC_W     = 2 * DATA_W + $clog2(MAX_TAPS);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_PTR, S_RUN, S_DRAIN, S_FIN
   } state_type;

   // request fields
   logic [LANE_W-1:0] req_lane;
   sample_type        req_re, req_im, req_coef;
   logic [IDX_W-1:0]  req_idx;
   logic              req_acc;

   assign req_lane = req_tdata[REQ_LANE_LO +: LANE_W];
   assign req_re   = req_tdata[REQ_RE_LO +: DATA_W];
   assign req_im   = req_tdata[REQ_IM_LO +: DATA_W];
   assign req_idx  = req_tdata[REQ_IDX_LO +: IDX_W];
   assign req_coef = req_tdata[REQ_COEF_LO +: DATA_W];
   assign req_acc  = req_tvalid && req_tready;

   // registers
   state_type               state_ff, state_in;
   logic [CW-1:0]           clr_ff, clr_in;
   logic [TW-1:0]           k_ff, k_in;
   logic [TW-1:0]           taps_ff, taps_in;
   logic [SW-1:0]           slot_ff, slot_in;
   logic [SW-1:0]           ptr_ff, ptr_in;
   logic [LANE_W-1:0]       lane_ff, lane_in;
   sample_type              x_re_ff, x_re_in, x_im_ff, x_im_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [TAP_REG_W-1:0]    tap_count_ff;
   logic                    complex_mode_ff;

   // memories
   logic [2*DATA_W-1:0] dly_mem [DLY_DEPTH];
   logic [DATA_W-1:0]   coef_mem [MAX_TAPS];
   logic [SW-1:0]       ptr_mem [LANES];
   logic [2*DATA_W-1:0] dly_rd_ff;
   logic [DATA_W-1:0]   coef_rd_ff;
   logic [SW-1:0]       ptr_rd_ff;

   logic                dly_we, coef_we, ptr_we;
   logic [DAW-1:0]      dly_waddr, dly_raddr;
   logic [CAW-1:0]      coef_waddr, coef_raddr;
   logic [LW-1:0]       ptr_waddr, ptr_raddr;
   logic [2*DATA_W-1:0] dly_wdata;
   logic [DATA_W-1:0]   coef_wdata;
   logic [SW-1:0]       ptr_wdata;

   // MAC interface
   mac_ctrl_type        mac_ctrl;
   sample_type          op_re, op_im, res_re, res_im;

   logic                out_free;
   logic                clearing;
   logic                lane_ok, idx_ok;
   logic [CMPW-1:0]     tc_wide, tc_clamp;
   logic [SW-1:0]       slot_dec, ptr_inc;
   logic [LW-1:0]       lane_idx;

   function automatic logic [SW-1:0] slot_prev(input logic [SW-1:0] s);
      return (s == '0) ? SW'(HIST_LEN - 1) : s - SW'(1);
   endfunction

   function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] s);
      return (s == SW'(HIST_LEN - 1)) ? '0 : s + SW'(1);
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign clearing   = (state_ff == S_CLEAR);
   assign lane_ok    = 32'(req_lane) < 32'(LANES);
   assign idx_ok     = 32'(req_idx) < 32'(MAX_TAPS);
   assign lane_idx   = LW'(lane_ff);
   assign ptr_inc    = slot_next(ptr_ff);

   assign tc_wide  = CMPW'(tap_count_ff);
   assign tc_clamp = (tc_wide == '0) ? CMPW'(1) :
                     (tc_wide > CMPW'(MAX_TAPS)) ? CMPW'(MAX_TAPS) : tc_wide;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      k_in         = '0;
      taps_in      = taps_ff;
      slot_in      = slot_ff;
      ptr_in       = ptr_ff;
      lane_in      = lane_ff;
      x_re_in      = x_re_ff;
      x_im_in      = x_im_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      slot_dec     = slot_prev(slot_ff);
      mac_ctrl     = '0;
      op_re        = x_re_ff;
      op_im        = x_im_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + CW'(1);
            if (clr_ff == CW'(CLR_LEN - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc && req_tuser[0] == KIND_SAMPLE && lane_ok) begin
               lane_in  = req_lane;
               x_re_in  = req_re;
               x_im_in  = complex_mode_ff ? req_im : sample_type'(0);
               taps_in  = TW'(tc_clamp);
               state_in = S_PTR;
            end
         end
         S_PTR: begin
            mac_ctrl.clear = 1'b1;
            mac_ctrl.feed  = 1'b1;
            slot_dec       = slot_prev(ptr_rd_ff);
            ptr_in         = ptr_rd_ff;
            slot_in        = slot_dec;
            k_in           = TW'(1);
            state_in       = (taps_ff == TW'(1)) ? S_DRAIN : S_RUN;
         end
         S_RUN: begin
            mac_ctrl.feed = 1'b1;
            op_re         = dly_rd_ff[DATA_W-1:0];
            op_im         = dly_rd_ff[2*DATA_W-1:DATA_W];
            slot_in       = slot_dec;
            k_in          = k_ff + TW'(1);
            if (k_ff == taps_ff - TW'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[RSP_LANE_LO +: LANE_W] = lane_ff;
               rsp_data_in[RSP_RE_LO +: DATA_W]   = res_re;
               rsp_data_in[RSP_IM_LO +: DATA_W]   = complex_mode_ff ? res_im : sample_type'(0);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         clr_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         tap_count_ff    <= TAP_REG_W'(1);
         complex_mode_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_TAP_COUNT:    tap_count_ff    <= csr_wdata[TAP_REG_W-1:0];
               REG_COMPLEX_MODE: complex_mode_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
      k_ff        <= k_in;
      taps_ff     <= taps_in;
      slot_ff     <= slot_in;
      ptr_ff      <= ptr_in;
      lane_ff     <= lane_in;
      x_re_ff     <= x_re_in;
      x_im_ff     <= x_im_in;
      rsp_data_ff <= rsp_data_in;
   end

   // memory ports
   assign dly_we     = (clearing && 32'(clr_ff) < 32'(DLY_DEPTH)) ||
                       (state_ff == S_FIN && out_free);
   assign dly_waddr  = clearing ? DAW'(clr_ff) : {lane_idx, ptr_ff};
   assign dly_wdata  = clearing ? '0 : {x_im_ff, x_re_ff};
   assign dly_raddr  = {lane_idx, slot_dec};

   assign coef_we    = (clearing && 32'(clr_ff) < 32'(MAX_TAPS)) ||
                       (req_acc && req_tuser[0] == KIND_COEF && idx_ok);
   assign coef_waddr = clearing ? CAW'(clr_ff) : CAW'(req_idx);
   assign coef_wdata = clearing ? '0 : req_coef;
   assign coef_raddr = k_in[CAW-1:0];

   assign ptr_we     = (clearing && 32'(clr_ff) < 32'(LANES)) ||
                       (state_ff == S_FIN && out_free);
   assign ptr_waddr  = clearing ? LW'(clr_ff) : lane_idx;
   assign ptr_wdata  = clearing ? '0 : ptr_inc;
   assign ptr_raddr  = LW'(req_lane);

   always_ff @(posedge clock) begin
      if (dly_we) begin
         dly_mem[dly_waddr] <= dly_wdata;
      end
      dly_rd_ff <= dly_mem[dly_raddr];
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= coef_wdata;
      end
      coef_rd_ff <= coef_mem[coef_raddr];
   end

   always_ff @(posedge clock) begin
      if (ptr_we) begin
         ptr_mem[ptr_waddr] <= ptr_wdata;
      end
      ptr_rd_ff <= ptr_mem[ptr_raddr];
   end

   mfir_mac #(
      .ACC_W (ACC_W)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mac_ctrl),
      .op_re   (op_re),
      .op_im   (op_im),
      .op_coef (sample_type'(coef_rd_ff)),
      .res_re  (res_re),
      .res_im  (res_im)
   );

   `MFIR_ASSERT_NOW(a_ptr_range, clock, reset, state_ff == S_PTR, 32'(ptr_rd_ff) < 32'(HIST_LEN), "history pointer out of range")
   `MFIR_ASSERT_NOW(a_tap_bound, clock, reset, state_ff == S_RUN, k_ff < taps_ff, "tap index beyond tap count")
   `MFIR_ASSERT_NEXT(a_coef_idle, clock, reset, req_acc && req_tuser[0] == KIND_COEF, state_ff == S_IDLE, "coefficient write left idle")
   `MFIR_ASSERT_NEXT(a_result_out, clock, reset, state_ff == S_FIN && out_free, rsp_tvalid && state_ff == S_IDLE, "result not presented")

endmodule

`default_nettype wire

@@ tb/multilane_fir_filter_unit_tb.sv @@
// ----------------------------------------------------------------------------
// multilane_fir_filter_unit_tb
// Self-checking bench for the multilane FIR filter. A directed table covers
// reset state, Q1.15 extremes, saturation, half-up rounding, tap counts out
// of range and real/complex switching; random phases under several register
// settings follow. Every sample is filtered by a local fixed-point model and
// each rsp_ item is compared field by field, with bursty req_ traffic and a
// stalling rsp_ side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multilane_fir_filter_unit_tb;

   import mfir_pkg::*;

   localparam int MAX_TAPS       = 64;
   localparam int LANES          = 4;
   localparam int HIST_LEN       = MAX_TAPS - 1;
   localparam int IDLE_CYCLES    = MAX_TAPS + 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 150;
   localparam int PHASES         = 9;
   localparam int TABLE_ROWS     = 23;

   typedef enum logic [1:0] {
      OP_SAMPLE,
      OP_COEF,
      OP_CSR
   } step_op_e;

   typedef struct packed {
      step_op_e    op;
      logic [1:0]  lane;
      logic [15:0] re;
      logic [15:0] im;
      logic [5:0]  sel;
      logic [15:0] val;
      logic        known;
      logic [15:0] k_re;
      logic [15:0] k_im;
   } step_t;

   typedef struct packed {
      logic [1:0]         lane;
      logic signed [15:0] re;
      logic signed [15:0] im;
   } fir_result_t;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic [REQ_USER_W-1:0]   req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_we;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   logic signed [15:0] coef_bank [MAX_TAPS];
   logic signed [15:0] hist_re [LANES][HIST_LEN];
   logic signed [15:0] hist_im [LANES][HIST_LEN];
   logic [6:0]         tap_reg;
   logic               cmode;

   fir_result_t filtered_queue [$];
   int          err_count    = 0;
   int          burst_left   = 0;
   int          stall_cycles = 0;
   int          ready_mode   = 0;
   int          mode_left    = 0;
   int          pattern_pos  = 0;

   step_t directed [TABLE_ROWS] = '{
      '{OP_SAMPLE, 2'd0, 16'h7FFF, 16'h8000, 6'd0,  16'h0000, 1'b1, 16'h0000, 16'h0000},
      '{OP_COEF,   2'd0, 16'h0000, 16'h0000, 6'd0,  16'h8000, 1'b0, 16'h0000, 16'h0000},
      '{OP_SAMPLE, 2'd1, 16'h8000, 16'h0000, 6'd0,  16'h0000, 1'b1, 16'h7FFF, 16'h0000},
      '{OP_SAMPLE, 2'd2, 16'h7FFF, 16'h8000, 6'd0,  16'h0000, 1'b1, 16'h8001, 16'h7FFF},
      '{OP_COEF,   2'd0, 16'h0000, 16'h0000, 6'd0,  16'h4000, 1'b0, 16'h0000, 16'h0000},
      '{OP_SAMPLE, 2'd3, 16'h0001, 16'hFFFF, 6'd0,  16'h0000, 1'b1, 16'h0001, 16'h0000},
      '{OP_COEF,   2'd0, 16'h0000, 16'h0000, 6'd63, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
      '{OP_COEF,   2'd0, 16'h0000, 16'h0000, 6'd1,  16'hFFFF, 1'b0, 16'h0000, 16'h0000},
      '{OP_COEF,   2'd0, 16'h0000, 16'h0000, 6'd2,  16'h8000, 1'b0, 16'h0000, 16'h0000},
      '{OP_CSR,    2'd0, 16'h0000, 16'h0000, 6'(REG_TAP_COUNT), 16'd64,
        1'b0, 16'h0000, 16'h0000},
      '{OP_SAMPLE, 2'd0, 16'h8000, 16'h7FFF, 6'd0,  16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{OP_SAMPLE, 2'd0, 16'h1234, 16'hEDCB, 6'd0,  16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{OP_CSR,    2'd0, 16'h0000, 16'h0000, 6'(REG_TAP_COUNT), 16'd0,
        1'b0, 16'h0000, 16'h0000},
      '{OP_SAMPLE, 2'd1, 16'h7FFF, 16'h7FFF, 6'd0,  16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{OP_CSR,    2'd0, 16'h0000, 16'h0000, 6'(REG_TAP_COUNT), 16'd127,
        1'b0, 16'h0000, 16'h0000},
      '{OP_SAMPLE, 2'd2, 16'h5555, 16'hAAAA, 6'd0,  16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{OP_CSR,    2'd0, 16'h0000, 16'h0000, 6'(REG_COMPLEX_MODE), 16'h007E,
        1'b0, 16'h0000, 16'h0000},
      '{OP_SAMPLE, 2'd3, 16'h8000, 16'h7FFF, 6'd0,  16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{OP_CSR,    2'd0, 16'h0000, 16'h0000, 6'(REG_TAP_COUNT), 16'd5,
        1'b0, 16'h0000, 16'h0000},
      '{OP_SAMPLE, 2'd3, 16'h0100, 16'h0F0F, 6'd0,  16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{OP_CSR,    2'd0, 16'h0000, 16'h0000, 6'(REG_COMPLEX_MODE), 16'h0001,
        1'b0, 16'h0000, 16'h0000},
      '{OP_SAMPLE, 2'd3, 16'h7FFF, 16'h8000, 6'd0,  16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{OP_SAMPLE, 2'd0, 16'hC000, 16'h3FFF, 6'd0,  16'h0000, 1'b0, 16'h0000, 16'h0000}
   };

   multilane_fir_filter_unit #(
      .MAX_TAPS (MAX_TAPS),
      .LANES    (LANES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic logic signed [15:0] round_to_q15(input longint acc);
      longint q;
      q = (acc + 64'sd16384) >>> 15;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   task automatic filter_sample(input logic [1:0] lane, input logic signed [15:0] xr,
                                input logic signed [15:0] xi_in, output fir_result_t res);
      int                 taps;
      logic signed [15:0] xi;
      longint             acc_re;
      longint             acc_im;
      taps = (tap_reg == 0) ? 1 : ((tap_reg > MAX_TAPS) ? MAX_TAPS : int'(tap_reg));
      xi = cmode ? xi_in : 16'sd0;
      acc_re = longint'(xr) * longint'(coef_bank[0]);
      acc_im = longint'(xi) * longint'(coef_bank[0]);
      for (int k = 1; k < taps; k++) begin
         acc_re += longint'(hist_re[lane][k-1]) * longint'(coef_bank[k]);
         acc_im += longint'(hist_im[lane][k-1]) * longint'(coef_bank[k]);
      end
      for (int k = HIST_LEN - 1; k > 0; k--) begin
         hist_re[lane][k] = hist_re[lane][k-1];
         hist_im[lane][k] = hist_im[lane][k-1];
      end
      hist_re[lane][0] = xr;
      hist_im[lane][0] = xi;
      res.lane = lane;
      res.re   = round_to_q15(acc_re);
      res.im   = cmode ? round_to_q15(acc_im) : 16'sd0;
   endtask

   task automatic send_item(input logic kind, input logic [1:0] lane,
                            input logic [15:0] re, input logic [15:0] im,
                            input logic [5:0] idx, input logic [15:0] coef,
                            input logic known, input logic [15:0] k_re,
                            input logic [15:0] k_im);
      int          gap;
      fir_result_t res;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(30, 80);
            gap = $urandom_range(0, 2);
         end else begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 10);
         end
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {coef, idx, im, re, lane};
      do @(posedge clock); while (req_tready !== 1'b1);
      if (kind == KIND_COEF) begin
         coef_bank[idx] = coef;
      end else begin
         filter_sample(lane, re, im, res);
         if (known) begin
            res.re = k_re;
            res.im = k_im;
         end
         filtered_queue.push_back(res);
      end
   endtask

   task automatic drain_outputs();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (filtered_queue.size() != 0);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [6:0] value);
      drain_outputs();
      repeat (IDLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_TAP_COUNT)
         tap_reg = value;
      else
         cmode = value[0];
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode <= $urandom_range(0, 2);
         mode_left  <= $urandom_range(16, 160);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= (pattern_pos % 14) >= 11;
      endcase
      pattern_pos <= pattern_pos + 1;
   end

   always @(posedge clock) begin
      fir_result_t got;
      fir_result_t want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got.lane = rsp_tdata[RSP_LANE_LO +: LANE_W];
         got.re   = rsp_tdata[RSP_RE_LO +: DATA_W];
         got.im   = rsp_tdata[RSP_IM_LO +: DATA_W];
         if (filtered_queue.size() == 0) begin
            $error("unexpected item: out_lane %0d out_re %0d out_im %0d",
                   got.lane, got.re, got.im);
            err_count++;
         end else begin
            want = filtered_queue.pop_front();
            if (got.lane !== want.lane) begin
               $error("out_lane: expected %0d, got %0d", want.lane, got.lane);
               err_count++;
            end
            if (got.re !== want.re) begin
               $error("out_re: expected %0d, got %0d", want.re, got.re);
               err_count++;
            end
            if (got.im !== want.im) begin
               $error("out_im: expected %0d, got %0d", want.im, got.im);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready)
          || csr_we) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      logic [6:0]  taps_pick;
      logic        cm_pick;
      logic [1:0]  lane;
      logic [5:0]  idx;
      logic [15:0] coef;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= KIND_SAMPLE;
      csr_we     <= 1'b0;
      csr_index  <= REG_TAP_COUNT;
      csr_wdata  <= '0;
      tap_reg = 7'd1;
      cmode   = 1'b1;
      for (int k = 0; k < MAX_TAPS; k++) coef_bank[k] = '0;
      for (int l = 0; l < LANES; l++) begin
         for (int k = 0; k < HIST_LEN; k++) begin
            hist_re[l][k] = '0;
            hist_im[l][k] = '0;
         end
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         case (directed[i].op)
            OP_SAMPLE: send_item(KIND_SAMPLE, directed[i].lane, directed[i].re,
                                 directed[i].im, '0, '0, directed[i].known,
                                 directed[i].k_re, directed[i].k_im);
            OP_COEF:   send_item(KIND_COEF, '0, '0, '0, directed[i].sel,
                                 directed[i].val, 1'b0, '0, '0);
            default:   write_csr(directed[i].sel[CSR_IDX_W-1:0], directed[i].val[6:0]);
         endcase
      end

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: taps_pick = 7'd64;
            1: taps_pick = 7'd1;
            2: taps_pick = 7'($urandom_range(2, 8));
            3: taps_pick = 7'd127;
            4: taps_pick = 7'd0;
            5: taps_pick = 7'($urandom_range(2, 16));
            6: taps_pick = 7'($urandom_range(17, 63));
            7: taps_pick = 7'($urandom_range(1, 12));
            default: taps_pick = 7'($urandom_range(0, 127));
         endcase
         case (p)
            1, 6: cm_pick = 1'b0;
            5, 8: cm_pick = 1'($urandom_range(0, 1));
            default: cm_pick = 1'b1;
         endcase
         write_csr(REG_TAP_COUNT, taps_pick);
         write_csr(REG_COMPLEX_MODE, {6'($urandom), cm_pick});
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) == 0)
               drain_outputs();
            if ($urandom_range(0, 99) < 15) begin
               if ($urandom_range(0, 1) == 0 && tap_reg > 1)
                  idx = 6'($urandom_range(0, (tap_reg > MAX_TAPS ? MAX_TAPS : tap_reg) - 1));
               else
                  idx = 6'($urandom);
               if ($urandom_range(0, 3) == 0)
                  coef = 16'($urandom);
               else
                  coef = 16'($signed(16'($urandom_range(0, 4095))) - 16'sd2048);
               send_item(KIND_COEF, 2'($urandom), 16'($urandom), 16'($urandom),
                         idx, coef, 1'b0, '0, '0);
            end else begin
               lane = 2'($urandom_range(0, LANES - 1));
               send_item(KIND_SAMPLE, lane, pick_sample(), pick_sample(),
                         6'($urandom), 16'($urandom), 1'b0, '0, '0);
            end
         end
      end

      drain_outputs();
      repeat (IDLE_CYCLES) @(posedge clock);
      if (filtered_queue.size() != 0) begin
         $error("%0d expected items never arrived", filtered_queue.size());
         err_count++;
      end
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/mfir_pkg.sv
rtl/core/mfir_mac.sv
rtl/core/multilane_fir_filter_unit.sv
tb/multilane_fir_filter_unit_tb.sv
